/* hw/rtl/frm_pkg.sv */
`timescale 1ns / 1ps

package frm_pkg;

  // Word widths
  localparam int W  = 32;               // operand and result word
  localparam int MW = W - 1;            // magnitude width
  localparam int KW = $clog2(W);        // common power-of-two count
  localparam int CW = $clog2(MW + 1);   // divider step counter

  localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [1:0] {
    FORM_WHOLE  = 2'd0,
    FORM_PROPER = 2'd1,
    FORM_MIXED  = 2'd2
  } form_e;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_ZERO_DEN = 2'd1,
    ERR_NOT_NEG  = 2'd2
  } err_e;

  // Which quotient the shared divider produces
  typedef enum logic [1:0] {
    DIV_NR = 2'd0,   // numerator / gcd
    DIV_DR = 2'd1,   // denominator / gcd
    DIV_WR = 2'd2    // reduced numerator / reduced denominator
  } div_sel_e;

  typedef struct packed {
    logic signed [W-1:0] numer_in;
    logic signed [W-1:0] denom_in;
  } in_item_t;

  typedef struct packed {
    logic signed [W-1:0] whole_part;
    logic signed [W-1:0] rem_numer;
    logic [MW-1:0]       reduced_denom;
    form_e               form;
    err_e                error;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     twos;
    logic     gcd_step;
    logic     gfix;
    logic     div_start;
    div_sel_e div_sel;
    logic     div_step;
    logic     finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic err;
    logic both_even;
    logic a_zero;
    logic div_busy;
    logic out_blocked;
  } sts_t;

endpackage

/* hw/rtl/frm_ctrl.sv */
`timescale 1ns / 1ps

module frm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  frm_pkg::sts_t sts_i,
  output frm_pkg::cmd_t cmd_o
);
  import frm_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TWOS   = 3'd1;
  localparam logic [2:0] S_GCD    = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DRUN   = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state_q, state_d;
  div_sel_e   sel_q, sel_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    sel_d         = sel_q;
    cmd_o         = '0;
    cmd_o.div_sel = sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_TWOS;
        end
      end
      S_TWOS: begin
        // strip common factors of two, bail out early on a bad operand
        if (sts_i.err) begin
          state_d = S_FIN;
        end else if (sts_i.both_even) begin
          cmd_o.twos = 1'b1;
        end else begin
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        if (sts_i.a_zero) begin
          cmd_o.gfix = 1'b1;
          sel_d      = DIV_NR;
          state_d    = S_DSTART;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DRUN;
      end
      S_DRUN: begin
        if (sts_i.div_busy) begin
          cmd_o.div_step = 1'b1;
        end else begin
          case (sel_q)
            DIV_NR: begin
              sel_d   = DIV_DR;
              state_d = S_DSTART;
            end
            DIV_DR: begin
              sel_d   = DIV_WR;
              state_d = S_DSTART;
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_FIN: begin
        // wait for room in the output register
        if (!sts_i.out_blocked) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= DIV_NR;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule

/* hw/rtl/frm_datapath.sv */
`timescale 1ns / 1ps

module frm_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  frm_pkg::cmd_t      cmd_i,
  output frm_pkg::sts_t      sts_o,
  input  frm_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output frm_pkg::out_item_t out_data_o
);
  import frm_pkg::*;

  // Operand registers
  logic [MW-1:0] a_q, b_q, nmag_q, dmag_q, g_q;
  logic [KW-1:0] k_q;
  logic          neg_q;
  err_e          err_q;

  // Divider and results
  logic [MW-1:0] rem_q, quo_q, dvs_q;
  logic [CW-1:0] cnt_q;
  div_sel_e      dsel_q;
  logic [MW-1:0] nr_q, dr_q, w_q, r_q;

  logic      out_valid_q;
  out_item_t out_q;

  // Load: magnitudes, sign and operand checks
  logic [W-1:0]  n_u, d_u, n_abs, d_abs;
  logic          nneg, dneg;
  logic [MW-1:0] nmag_ld, dmag_ld;
  err_e          err_ld;

  assign n_u     = in_data_i.numer_in;
  assign d_u     = in_data_i.denom_in;
  assign nneg    = n_u[W-1];
  assign dneg    = d_u[W-1];
  assign n_abs   = nneg ? (~n_u + 1'b1) : n_u;
  assign d_abs   = dneg ? (~d_u + 1'b1) : d_u;
  assign nmag_ld = n_abs[MW-1:0];
  assign dmag_ld = d_abs[MW-1:0];

  always_comb begin
    if (d_u == '0) begin
      err_ld = ERR_ZERO_DEN;
    end else if ((n_u == MIN_VAL) || (d_u == MIN_VAL)) begin
      err_ld = ERR_NOT_NEG;
    end else begin
      err_ld = ERR_OK;
    end
  end

  // Divider step: shift in one dividend bit, trial subtract
  logic [W-1:0]  shifted;
  logic [W:0]    diff;
  logic          ge;
  logic [MW-1:0] rem_n, quo_n;

  assign shifted = {rem_q, quo_q[MW-1]};
  assign diff    = {1'b0, shifted} - {2'b0, dvs_q};
  assign ge      = ~diff[W];
  assign rem_n   = ge ? diff[MW-1:0] : shifted[MW-1:0];
  assign quo_n   = {quo_q[MW-2:0], ge};

  // Finish: sign, form code
  logic [W-1:0] w_ext, r_ext;
  form_e        form_n;

  assign w_ext = {1'b0, w_q};
  assign r_ext = {1'b0, r_q};

  always_comb begin
    if (dr_q == MW'(1)) begin
      form_n = FORM_WHOLE;
    end else if (w_q != '0) begin
      form_n = FORM_MIXED;
    end else begin
      form_n = FORM_PROPER;
    end
  end

  // Status
  assign sts_o.err         = (err_q != ERR_OK);
  assign sts_o.both_even   = ~a_q[0] & ~b_q[0];
  assign sts_o.a_zero      = (a_q == '0);
  assign sts_o.div_busy    = (cnt_q != '0);
  assign sts_o.out_blocked = out_valid_q & out_stall_i;

  // Operand and gcd registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= nmag_ld;
      b_q    <= dmag_ld;
      nmag_q <= nmag_ld;
      dmag_q <= dmag_ld;
      k_q    <= '0;
      neg_q  <= (nneg ^ dneg) && (nmag_ld != '0);
      err_q  <= err_ld;
    end else if (cmd_i.twos) begin
      a_q <= a_q >> 1;
      b_q <= b_q >> 1;
      k_q <= k_q + 1'b1;
    end else if (cmd_i.gcd_step) begin
      // binary gcd step, b stays nonzero
      if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q >= b_q) begin
        a_q <= (a_q - b_q) >> 1;
      end else begin
        b_q <= (b_q - a_q) >> 1;
      end
    end
    if (cmd_i.gfix) begin
      g_q <= b_q << k_q;
    end
  end

  // Shared restoring divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q  <= '0;
      dsel_q <= cmd_i.div_sel;
      case (cmd_i.div_sel)
        DIV_NR: begin
          quo_q <= nmag_q;
          dvs_q <= g_q;
        end
        DIV_DR: begin
          quo_q <= dmag_q;
          dvs_q <= g_q;
        end
        default: begin
          quo_q <= nr_q;
          dvs_q <= dr_q;
        end
      endcase
    end else if (cmd_i.div_step) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
      if (cnt_q == CW'(1)) begin
        case (dsel_q)
          DIV_NR: nr_q <= quo_n;
          DIV_DR: dr_q <= quo_n;
          default: begin
            w_q <= quo_n;
            r_q <= rem_n;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= CW'(MW);
    end else if (cmd_i.div_step && (cnt_q != '0)) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (err_q != ERR_OK) begin
        out_q.whole_part    <= '0;
        out_q.rem_numer     <= '0;
        out_q.reduced_denom <= '0;
        out_q.form          <= FORM_WHOLE;
      end else begin
        out_q.whole_part    <= neg_q ? (~w_ext + 1'b1) : w_ext;
        out_q.rem_numer     <= neg_q ? (~r_ext + 1'b1) : r_ext;
        out_q.reduced_denom <= dr_q;
        out_q.form          <= form_n;
      end
      out_q.error <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hw/rtl/fraction_reduce_mixed.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// input     in         in_valid_i / in_stall_o  in_data_i  (numer_in, denom_in)
// output    out        out_valid_o/ out_stall_i out_data_o (whole_part, rem_numer,
//                                                reduced_denom, form, error)
//
// One item at a time: the input stalls until the item's result is written. Common twos
// and binary gcd steps come first, then one shared restoring divider runs three
// 31-step divisions (numerator/gcd, denominator/gcd, whole part and remainder).
// A zero denominator or most-negative operand skips the gcd and divider steps and
// goes from the twos state straight to the finish state.
// Reset is asynchronous, active low; it clears the controller and output valid.
// A stalled result sits in the output register; the next item is taken meanwhile
// and holds in its final state until the output register is free.

module fraction_reduce_mixed (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  frm_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output frm_pkg::out_item_t out_data_o
);
  import frm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  frm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  frm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* hw/rtl/frm_checker.sv */
`timescale 1ns / 1ps

module frm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input frm_pkg::out_item_t out_data_o
);
  import frm_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i & ~in_stall_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // block is busy right after taking an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input not stalled after transfer");

  // no result can appear in the cycle after a transfer
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(out_valid_o))
    else $error("result too early");

  // good result always has a nonzero denominator
  a_denom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.error == ERR_OK) |-> out_data_o.reduced_denom != '0)
    else $error("zero reduced denominator");

endmodule

bind fraction_reduce_mixed frm_checker u_frm_checker (.*);

/* test/fraction_reduce_mixed_tb.sv */
`timescale 1ns / 1ps

module fraction_reduce_mixed_tb;
  import frm_pkg::*;

  localparam int            NUM_RANDOM = 550;
  localparam int            IDLE_LIMIT = 2000;  // several times the slowest item
  localparam int            DRAIN_WAIT = 250;   // beyond the longest item latency
  localparam logic [W-1:0]  MAX_VAL    = {1'b0, {(W-1){1'b1}}};

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_item_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_data_o;

  in_item_t   operand_q[$];    // fractions waiting to be driven
  out_item_t  reduced_q[$];    // reduced results still to arrive
  int         in_count     = 0;
  int         out_count    = 0;
  int         mismatch_cnt = 0;
  int         idle_cycles  = 0;
  int         in_wait      = 0;
  int         out_hold     = 2;
  logic       in_taken     = 1'b0;
  logic       out_taken    = 1'b0;

  fraction_reduce_mixed u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Expected reduction: sign moved to numerator, divided by gcd, split into
  // whole part and remainder
  function automatic out_item_t reduce_fraction(in_item_t frac);
    out_item_t    res;
    logic [W-1:0] n_mag, d_mag, a, b, t, num_r, den_r, whole_mag, rem_mag;
    logic         neg;
    res       = '0;
    res.form  = FORM_WHOLE;
    res.error = ERR_OK;
    if (frac.denom_in == '0) begin
      res.error = ERR_ZERO_DEN;
      return res;
    end
    if (frac.numer_in == MIN_VAL || frac.denom_in == MIN_VAL) begin
      res.error = ERR_NOT_NEG;
      return res;
    end
    n_mag = frac.numer_in[W-1] ? -frac.numer_in : frac.numer_in;
    d_mag = frac.denom_in[W-1] ? -frac.denom_in : frac.denom_in;
    neg   = (frac.numer_in[W-1] ^ frac.denom_in[W-1]) && (n_mag != '0);
    // Euclid; a zero numerator leaves the denominator as the gcd
    a = n_mag;
    b = d_mag;
    while (b != '0) begin
      t = a % b;
      a = b;
      b = t;
    end
    num_r     = n_mag / a;
    den_r     = d_mag / a;
    whole_mag = num_r / den_r;
    rem_mag   = num_r % den_r;
    res.whole_part    = neg ? -whole_mag : whole_mag;
    res.rem_numer     = neg ? -rem_mag : rem_mag;
    res.reduced_denom = den_r[MW-1:0];
    if (den_r == 1)
      res.form = FORM_WHOLE;
    else if (whole_mag != '0)
      res.form = FORM_MIXED;
    else
      res.form = FORM_PROPER;
    return res;
  endfunction

  task automatic add_fraction(input logic [W-1:0] n, input logic [W-1:0] d);
    in_item_t frac;
    frac.numer_in = n;
    frac.denom_in = d;
    operand_q.push_back(frac);
  endtask

  // Input driver: random gap before each transfer, no gaps in some stretches
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_wait > 0) begin
        in_valid_i <= 1'b0;
        in_wait    <= in_wait - 1;
      end else if (operand_q.size() > 0) begin
        in_data_i  <= operand_q.pop_front();
        in_valid_i <= 1'b1;
        in_wait    <= (in_count[6:5] == 2'b01) ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output stall: drawn per result, counted down while a result is offered
  always @(negedge clk_i) begin
    int hold_next;
    if (rst_ni) begin
      if (out_taken)
        hold_next = (out_count[6:5] == 2'b10) ? 0 : $urandom_range(0, 3);
      else
        hold_next = out_hold;
      out_stall_i <= (hold_next > 0);
      out_hold    <= (out_valid_o && hold_next > 0) ? hold_next - 1 : hold_next;
    end
  end

  // Monitor: predict on input transfers, check on output transfers
  always @(posedge clk_i) begin
    out_item_t exp_r;
    logic      in_fire, out_fire;
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    in_taken  <= in_fire;
    out_taken <= out_fire;
    if (in_fire) begin
      reduced_q.push_back(reduce_fraction(in_data_i));
      in_count <= in_count + 1;
    end
    if (out_fire) begin
      out_count <= out_count + 1;
      if (reduced_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        mismatch_cnt++;
      end else begin
        exp_r = reduced_q.pop_front();
        if (out_data_o.whole_part !== exp_r.whole_part) begin
          $display("%0t: whole_part expected %0d actual %0d", $time,
                   exp_r.whole_part, out_data_o.whole_part);
          mismatch_cnt++;
        end
        if (out_data_o.rem_numer !== exp_r.rem_numer) begin
          $display("%0t: rem_numer expected %0d actual %0d", $time,
                   exp_r.rem_numer, out_data_o.rem_numer);
          mismatch_cnt++;
        end
        if (out_data_o.reduced_denom !== exp_r.reduced_denom) begin
          $display("%0t: reduced_denom expected %0d actual %0d", $time,
                   exp_r.reduced_denom, out_data_o.reduced_denom);
          mismatch_cnt++;
        end
        if (out_data_o.form !== exp_r.form) begin
          $display("%0t: form expected %0d actual %0d", $time,
                   exp_r.form, out_data_o.form);
          mismatch_cnt++;
        end
        if (out_data_o.error !== exp_r.error) begin
          $display("%0t: error expected %0d actual %0d", $time,
                   exp_r.error, out_data_o.error);
          mismatch_cnt++;
        end
      end
    end
    // Watchdog on cycles without any transfer
    if (in_fire || out_fire || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run
  initial begin
    logic [W-1:0] n, d, k;
    int           kind;
    // Directed: zeros, errors, signs, extremes, negative mixed value
    add_fraction(0, 5);
    add_fraction(0, -5);
    add_fraction(7, 0);
    add_fraction(0, 0);
    add_fraction(MIN_VAL, 0);
    add_fraction(MIN_VAL, 3);
    add_fraction(3, MIN_VAL);
    add_fraction(MIN_VAL, MIN_VAL);
    add_fraction(-7, 2);
    add_fraction(7, 2);
    add_fraction(7, -2);
    add_fraction(-7, -2);
    add_fraction(1, 3);
    add_fraction(-1, 3);
    add_fraction(6, 3);
    add_fraction(-6, -3);
    add_fraction(12, 18);
    add_fraction(1, -1);
    add_fraction(MAX_VAL, 1);
    add_fraction(MAX_VAL, MAX_VAL);
    add_fraction(-MAX_VAL, MAX_VAL);
    add_fraction(1, MAX_VAL);
    add_fraction(MAX_VAL, 2);
    add_fraction(32'h4000_0000, 32'h7FFF_FFFE);
    add_fraction(-MAX_VAL, -1);

    // Random: full-range words, shared factors, small values, powers of two, special operands
    for (int i = 0; i < NUM_RANDOM; i++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          n = $urandom();
          d = $urandom();
        end
        3, 4, 5: begin
          k = $urandom_range(1, 1 << 15);
          n = k * $urandom_range(0, 1 << 15);
          d = k * $urandom_range(1, 1 << 15);
          if ($urandom_range(0, 1)) n = -n;
          if ($urandom_range(0, 1)) d = -d;
        end
        6: begin
          n = $signed($urandom_range(0, 40)) - 20;
          d = $signed($urandom_range(0, 40)) - 20;
        end
        7: begin
          n = $urandom() >> $urandom_range(0, 31) << $urandom_range(0, 20);
          d = ($urandom() | 1) << $urandom_range(0, 30);
          if ($urandom_range(0, 1)) n = -n;
          if ($urandom_range(0, 1)) d = -d;
        end
        default: begin
          n = $urandom();
          d = $urandom();
          case ($urandom_range(0, 4))
            0: n = '0;
            1: d = '0;
            2: n = MIN_VAL;
            3: d = MIN_VAL;
            default: d = $urandom_range(0, 1) ? 1 : -1;
          endcase
        end
      endcase
      add_fraction(n, d);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (operand_q.size() > 0 || in_valid_i) @(posedge clk_i);
    while (reduced_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_cnt == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
